// ----- design/mtb_pkg.sv -----
// ----------------------------------------------------------------------------
// mtb_pkg: shared types and constants of the token bucket table
// Holds the stream field layout, opcode and status codes, the controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mtb_pkg;

  // Default sizing, handed to the top level parameters.
  localparam int NUM_BUCKETS_DEF = 8;
  localparam int TOKEN_BITS_DEF  = 16;

  // Field widths of the stream channels.
  localparam int OP_W     = 3;
  localparam int INDEX_W  = 8;
  localparam int AMOUNT_W = 16;
  localparam int STATUS_W = 2;

  // Input tdata layout, lowest bit first.
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_RATE_LSB  = IN_IDX_LSB + INDEX_W;
  localparam int IN_BURST_LSB = IN_RATE_LSB + AMOUNT_W;
  localparam int IN_REQ_LSB   = IN_BURST_LSB + AMOUNT_W;
  localparam int IN_DATA_W    = IN_REQ_LSB + AMOUNT_W;

  // Output tdata layout, lowest bit first.
  localparam int OUT_GRANT_LSB = 0;
  localparam int OUT_SLOT_LSB  = OUT_GRANT_LSB + AMOUNT_W;
  localparam int OUT_DATA_W    = OUT_SLOT_LSB + INDEX_W;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_CREATE   = 3'd1;
  localparam logic [OP_W-1:0] OP_FETCH    = 3'd2;
  localparam logic [OP_W-1:0] OP_DESTROY  = 3'd3;
  localparam logic [OP_W-1:0] OP_KILL_ALL = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TICK_RD,
    S_TICK_WR,
    S_CRT_SCAN,
    S_FET_WR,
    S_RESP
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic                capture;
    logic                cnt_inc;
    logic                addr_idx;
    logic                mem_rd;
    logic                tick_wr;
    logic                fetch_wr;
    logic                create_wr;
    logic                kill_one;
    logic                kill_all;
    logic                set_status;
    logic [STATUS_W-1:0] status_code;
    logic                out_load;
  } ctrl_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            idx_range;
    logic            idx_live;
    logic            cnt_done;
    logic            cur_live;
    logic            out_free;
  } dp_stat_t;

endpackage

// ----- design/mtb_ctrl.sv -----
// ----------------------------------------------------------------------------
// mtb_ctrl: sequencing controller of the token bucket table
// Decodes each captured transaction and steps the datapath through the
// table walk or the read-modify-write that the opcode needs.
// ----------------------------------------------------------------------------
module mtb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mtb_pkg::dp_stat_t stat,
  output mtb_pkg::ctrl_cmd_t cmd
);

  mtb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = (state_r == mtb_pkg::S_IDLE);
    unique case (state_r)
      mtb_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = mtb_pkg::S_DECODE;
        end
      end
      mtb_pkg::S_DECODE: begin
        unique case (stat.op)
          mtb_pkg::OP_TICK: begin
            state_nxt = mtb_pkg::S_TICK_RD;
          end
          mtb_pkg::OP_CREATE: begin
            state_nxt = mtb_pkg::S_CRT_SCAN;
          end
          mtb_pkg::OP_FETCH, mtb_pkg::OP_DESTROY: begin
            priority if (stat.idx_range) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = mtb_pkg::ST_RANGE;
              state_nxt       = mtb_pkg::S_RESP;
            end else if (!stat.idx_live) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = mtb_pkg::ST_ABSENT;
              state_nxt       = mtb_pkg::S_RESP;
            end else if (stat.op == mtb_pkg::OP_FETCH) begin
              cmd.mem_rd   = 1'b1;
              cmd.addr_idx = 1'b1;
              state_nxt    = mtb_pkg::S_FET_WR;
            end else begin
              cmd.kill_one = 1'b1;
              state_nxt    = mtb_pkg::S_RESP;
            end
          end
          mtb_pkg::OP_KILL_ALL: begin
            cmd.kill_all = 1'b1;
            state_nxt    = mtb_pkg::S_RESP;
          end
          default: begin
            state_nxt = mtb_pkg::S_RESP;
          end
        endcase
      end
      mtb_pkg::S_TICK_RD: begin
        priority if (stat.cnt_done) begin
          state_nxt = mtb_pkg::S_RESP;
        end else if (stat.cur_live) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = mtb_pkg::S_TICK_WR;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      mtb_pkg::S_TICK_WR: begin
        cmd.tick_wr = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = mtb_pkg::S_TICK_RD;
      end
      mtb_pkg::S_CRT_SCAN: begin
        priority if (stat.cnt_done) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = mtb_pkg::ST_FULL;
          state_nxt       = mtb_pkg::S_RESP;
        end else if (!stat.cur_live) begin
          cmd.create_wr = 1'b1;
          state_nxt     = mtb_pkg::S_RESP;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      mtb_pkg::S_FET_WR: begin
        cmd.fetch_wr = 1'b1;
        cmd.addr_idx = 1'b1;
        state_nxt    = mtb_pkg::S_RESP;
      end
      mtb_pkg::S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = mtb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mtb_pkg::S_IDLE;
      end
    endcase
  end

  // A new transaction is taken only once the previous one is finished.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a transaction was in progress");

  // A tick write-back always follows the read of the same entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_wr |-> $past(cmd.mem_rd))
    else $error("tick write-back without a preceding read");

  // Handing over the result returns the controller to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> in_tready)
    else $error("controller not idle after result hand-over");

endmodule

// ----- design/mtb_dp.sv -----
// ----------------------------------------------------------------------------
// mtb_dp: datapath of the token bucket table
// Holds the captured request, the live bits, the bucket memory, the walk
// counter, the result fields and the output register.
// ----------------------------------------------------------------------------
module mtb_dp #(
  parameter int NUM_BUCKETS = mtb_pkg::NUM_BUCKETS_DEF,
  parameter int TOKEN_BITS  = mtb_pkg::TOKEN_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [mtb_pkg::OP_W-1:0]     in_opcode,
  input  logic [mtb_pkg::INDEX_W-1:0]  in_index,
  input  logic [mtb_pkg::AMOUNT_W-1:0] in_rate,
  input  logic [mtb_pkg::AMOUNT_W-1:0] in_burst,
  input  logic [mtb_pkg::AMOUNT_W-1:0] in_request,
  input  mtb_pkg::ctrl_cmd_t           cmd,
  output mtb_pkg::dp_stat_t            stat,
  input  logic                         out_tready,
  output logic                         out_valid,
  output logic [mtb_pkg::STATUS_W-1:0] out_status,
  output logic [mtb_pkg::AMOUNT_W-1:0] out_granted,
  output logic [mtb_pkg::INDEX_W-1:0]  out_slot
);

  localparam int IDX_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CNT_W  = $clog2(NUM_BUCKETS + 1);
  localparam int CMP_W  = (TOKEN_BITS > mtb_pkg::AMOUNT_W) ? TOKEN_BITS : mtb_pkg::AMOUNT_W;
  localparam int WORD_W = 3 * TOKEN_BITS;

  // Captured request.
  logic [mtb_pkg::OP_W-1:0]     op_r;
  logic [mtb_pkg::INDEX_W-1:0]  idx_r;
  logic [TOKEN_BITS-1:0]        rate_r;
  logic [TOKEN_BITS-1:0]        burst_r;
  logic [mtb_pkg::AMOUNT_W-1:0] req_r;

  // Table state.
  logic [NUM_BUCKETS-1:0] live_r, live_nxt;
  logic [WORD_W-1:0]      mem [NUM_BUCKETS];
  logic [WORD_W-1:0]      rd_word_r;
  logic [CNT_W-1:0]       cnt_r;

  // Result fields and output register.
  logic [mtb_pkg::STATUS_W-1:0] res_status_r;
  logic [mtb_pkg::AMOUNT_W-1:0] res_granted_r;
  logic [mtb_pkg::INDEX_W-1:0]  res_slot_r;
  logic                         out_valid_r;
  logic [mtb_pkg::STATUS_W-1:0] out_status_r;
  logic [mtb_pkg::AMOUNT_W-1:0] out_granted_r;
  logic [mtb_pkg::INDEX_W-1:0]  out_slot_r;

  logic [IDX_W-1:0]      idx_sel;
  logic [IDX_W-1:0]      cnt_idx;
  logic [IDX_W-1:0]      addr;
  logic [TOKEN_BITS-1:0] rd_tok;
  logic [TOKEN_BITS-1:0] rd_rate;
  logic [TOKEN_BITS-1:0] rd_burst;
  logic [TOKEN_BITS:0]   tick_sum;
  logic [TOKEN_BITS-1:0] tick_tok;
  logic [CMP_W-1:0]      req_ext;
  logic [CMP_W-1:0]      tok_ext;
  logic [CMP_W-1:0]      grant;
  logic                  mem_we;
  logic [WORD_W-1:0]     wr_word;

  assign idx_sel = idx_r[IDX_W-1:0];
  assign cnt_idx = cnt_r[IDX_W-1:0];
  assign addr    = cmd.addr_idx ? idx_sel : cnt_idx;

  // Memory word layout: burst, rate, tokens from the top bits down.
  assign rd_tok   = rd_word_r[TOKEN_BITS-1:0];
  assign rd_rate  = rd_word_r[2*TOKEN_BITS-1:TOKEN_BITS];
  assign rd_burst = rd_word_r[WORD_W-1:2*TOKEN_BITS];

  // Refill saturates at the burst limit.
  assign tick_sum = {1'b0, rd_tok} + {1'b0, rd_rate};
  assign tick_tok = (tick_sum > {1'b0, rd_burst}) ? rd_burst : tick_sum[TOKEN_BITS-1:0];

  // The grant is the lesser of the request and the tokens held.
  assign req_ext = CMP_W'(req_r);
  assign tok_ext = CMP_W'(rd_tok);
  assign grant   = (req_ext < tok_ext) ? req_ext : tok_ext;

  assign mem_we = cmd.tick_wr | cmd.fetch_wr | cmd.create_wr;

  always_comb begin
    priority if (cmd.create_wr) begin
      wr_word = {burst_r, rate_r, {TOKEN_BITS{1'b0}}};
    end else if (cmd.tick_wr) begin
      wr_word = {rd_burst, rd_rate, tick_tok};
    end else begin
      wr_word = {rd_burst, rd_rate, rd_tok - grant[TOKEN_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wr_word;
    end
    if (cmd.mem_rd) begin
      rd_word_r <= mem[addr];
    end
  end

  always_comb begin
    live_nxt = live_r;
    if (cmd.kill_all) begin
      live_nxt = '0;
    end
    if (cmd.kill_one) begin
      live_nxt[idx_sel] = 1'b0;
    end
    if (cmd.create_wr) begin
      live_nxt[cnt_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      live_r <= live_nxt;
      if (cmd.capture) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r          <= in_opcode;
      idx_r         <= in_index;
      rate_r        <= TOKEN_BITS'(in_rate);
      burst_r       <= TOKEN_BITS'(in_burst);
      req_r         <= in_request;
      res_status_r  <= mtb_pkg::ST_OK;
      res_granted_r <= '0;
      res_slot_r    <= '0;
    end else begin
      if (cmd.set_status) begin
        res_status_r <= cmd.status_code;
      end
      if (cmd.fetch_wr) begin
        res_granted_r <= grant[mtb_pkg::AMOUNT_W-1:0];
      end
      if (cmd.create_wr) begin
        res_slot_r <= mtb_pkg::INDEX_W'(cnt_r);
      end
    end
    if (cmd.out_load) begin
      out_status_r  <= res_status_r;
      out_granted_r <= res_granted_r;
      out_slot_r    <= res_slot_r;
    end
  end

  assign stat.op        = op_r;
  assign stat.idx_range = ({1'b0, idx_r} >= (mtb_pkg::INDEX_W + 1)'(NUM_BUCKETS));
  assign stat.idx_live  = live_r[idx_sel];
  assign stat.cnt_done  = (cnt_r == CNT_W'(NUM_BUCKETS));
  assign stat.cur_live  = live_r[cnt_idx];
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_granted = out_granted_r;
  assign out_slot    = out_slot_r;

  // A waiting result is never overwritten.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result loaded over one still waiting");

  // Create only claims a slot that is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.create_wr |-> (!stat.cnt_done && !live_r[cnt_idx]))
    else $error("create claimed a live slot");

  // A fetch never grants more than was asked for.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch_wr |=> (res_granted_r <= req_r))
    else $error("grant exceeds request");

endmodule

// ----- design/multi_token_bucket_table.sv -----
// ----------------------------------------------------------------------------
// multi_token_bucket_table: table of token bucket rate limiters
// Top level: unpacks the stream channels and joins controller and datapath.
// ----------------------------------------------------------------------------
// Usage
// Each input transaction carries an opcode on in_tuser (tick, create, fetch,
// destroy one, destroy all) and its operands on in_tdata; each produces
// exactly one result transaction with a status on out_tuser and the granted
// token count and created slot on out_tdata.
// One transaction is worked on at a time. Create and tick walk over the
// table one entry per cycle; create stops at the first free slot, or at the
// end when the table is full, and a tick adds a read-modify-write on the
// single bucket memory for each live bucket it meets. A fetch reads its
// bucket and writes it back; destroy and destroy all only clear live bits.
// The result sits in an output register, so the next input is accepted while
// a result waits; if the receiver stalls with one result held and another
// finished, the block holds the second in its datapath and stops accepting.
// Reset clears every live bit at once and empties the output; no clearing
// pass over the memory is needed.
// ----------------------------------------------------------------------------
module multi_token_bucket_table #(
  parameter int NUM_BUCKETS = mtb_pkg::NUM_BUCKETS_DEF,
  parameter int TOKEN_BITS  = mtb_pkg::TOKEN_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // bucket_index[7:0], fill_rate[23:8], burst_limit[39:24], request_amount[55:40]
  input  logic [mtb_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode[2:0]
  input  logic [mtb_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // granted[15:0], new_slot[23:16]
  output logic [mtb_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [mtb_pkg::STATUS_W-1:0]   out_tuser
);

  mtb_pkg::ctrl_cmd_t cmd;
  mtb_pkg::dp_stat_t  stat;

  logic [mtb_pkg::AMOUNT_W-1:0] granted;
  logic [mtb_pkg::INDEX_W-1:0]  new_slot;

  // The controller sequences each transaction; it only ever sees the
  // datapath through the command and status bundles.
  mtb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath captures the fields straight from the input bus on the
  // accepting edge.
  mtb_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .TOKEN_BITS  (TOKEN_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_opcode   (in_tuser),
    .in_index    (in_tdata[mtb_pkg::IN_IDX_LSB +: mtb_pkg::INDEX_W]),
    .in_rate     (in_tdata[mtb_pkg::IN_RATE_LSB +: mtb_pkg::AMOUNT_W]),
    .in_burst    (in_tdata[mtb_pkg::IN_BURST_LSB +: mtb_pkg::AMOUNT_W]),
    .in_request  (in_tdata[mtb_pkg::IN_REQ_LSB +: mtb_pkg::AMOUNT_W]),
    .cmd         (cmd),
    .stat        (stat),
    .out_tready  (out_tready),
    .out_valid   (out_tvalid),
    .out_status  (out_tuser),
    .out_granted (granted),
    .out_slot    (new_slot)
  );

  assign out_tdata = {new_slot, granted};

endmodule

// ----- bench/bucket_table_checker.sv -----
// ----------------------------------------------------------------------------
// bucket_table_checker: scoreboard for the token bucket table
// Keeps its own copy of the bucket table, works out the reply due for each
// accepted request and compares every accepted reply with the oldest one due.
// ----------------------------------------------------------------------------
module bucket_table_checker #(
  parameter int NUM_BUCKETS = mtb_pkg::NUM_BUCKETS_DEF,
  parameter int TOKEN_BITS  = mtb_pkg::TOKEN_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // bucket_index[7:0], fill_rate[23:8], burst_limit[39:24], request_amount[55:40]
  input  logic [mtb_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode[2:0]
  input  logic [mtb_pkg::OP_W-1:0]       in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // granted[15:0], new_slot[23:16]
  input  logic [mtb_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  input  logic [mtb_pkg::STATUS_W-1:0]   out_tuser,
  output int                             fail_count,
  output int                             replies_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [mtb_pkg::STATUS_W-1:0] status;
    logic [mtb_pkg::AMOUNT_W-1:0] granted;
    logic [mtb_pkg::INDEX_W-1:0]  new_slot;
  } reply_t;

  // Shadow copy of the bucket table.
  logic                  live_q   [NUM_BUCKETS];
  logic [TOKEN_BITS-1:0] tokens_q [NUM_BUCKETS];
  logic [TOKEN_BITS-1:0] rate_q   [NUM_BUCKETS];
  logic [TOKEN_BITS-1:0] burst_q  [NUM_BUCKETS];

  reply_t replies_expected[$];

  initial begin
    fail_count  = 0;
    replies_due = 0;
  end

  task automatic report_mismatch(input string what, input longint unsigned seen,
                                 input longint unsigned wanted);
    if (fail_count < PRINT_LIMIT) begin
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, seen,
               wanted);
    end
    fail_count++;
  endtask

  task automatic clear_table();
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      live_q[i]   = 1'b0;
      tokens_q[i] = '0;
      rate_q[i]   = '0;
      burst_q[i]  = '0;
    end
  endtask

  // Applies one request to the shadow table and returns the reply it earns.
  task automatic apply_bucket_op(input logic [mtb_pkg::OP_W-1:0] op,
                                 input logic [mtb_pkg::INDEX_W-1:0] idx,
                                 input logic [mtb_pkg::AMOUNT_W-1:0] rate,
                                 input logic [mtb_pkg::AMOUNT_W-1:0] burst,
                                 input logic [mtb_pkg::AMOUNT_W-1:0] req,
                                 output reply_t reply);
    logic [TOKEN_BITS:0] sum;
    logic [31:0]         held;
    logic [31:0]         grant;
    bit                  found;
    reply = '0;
    found = 1'b0;
    case (op)
      mtb_pkg::OP_TICK: begin
        for (int i = 0; i < NUM_BUCKETS; i++) begin
          if (live_q[i]) begin
            sum = {1'b0, tokens_q[i]} + {1'b0, rate_q[i]};
            if (sum > {1'b0, burst_q[i]}) sum = {1'b0, burst_q[i]};
            tokens_q[i] = sum[TOKEN_BITS-1:0];
          end
        end
      end
      mtb_pkg::OP_CREATE: begin
        reply.status = mtb_pkg::ST_FULL;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
          if (!found && !live_q[i]) begin
            found          = 1'b1;
            live_q[i]      = 1'b1;
            tokens_q[i]    = '0;
            rate_q[i]      = TOKEN_BITS'(rate);
            burst_q[i]     = TOKEN_BITS'(burst);
            reply.status   = mtb_pkg::ST_OK;
            reply.new_slot = mtb_pkg::INDEX_W'(i);
          end
        end
      end
      mtb_pkg::OP_FETCH, mtb_pkg::OP_DESTROY: begin
        if (int'(idx) >= NUM_BUCKETS) begin
          reply.status = mtb_pkg::ST_RANGE;
        end else if (!live_q[idx]) begin
          reply.status = mtb_pkg::ST_ABSENT;
        end else if (op == mtb_pkg::OP_FETCH) begin
          held          = 32'(tokens_q[idx]);
          grant         = (32'(req) < held) ? 32'(req) : held;
          tokens_q[idx] = TOKEN_BITS'(held - grant);
          reply.granted = mtb_pkg::AMOUNT_W'(grant);
        end else begin
          live_q[idx]   = 1'b0;
          tokens_q[idx] = '0;
        end
      end
      mtb_pkg::OP_KILL_ALL: begin
        for (int i = 0; i < NUM_BUCKETS; i++) begin
          live_q[i]   = 1'b0;
          tokens_q[i] = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch_channels
    reply_t seen;
    reply_t wanted;
    reply_t predicted;
    if (!rst_n) begin
      clear_table();
      replies_expected.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen.status   = out_tuser;
        seen.granted  = out_tdata[mtb_pkg::OUT_GRANT_LSB +: mtb_pkg::AMOUNT_W];
        seen.new_slot = out_tdata[mtb_pkg::OUT_SLOT_LSB +: mtb_pkg::INDEX_W];
        if (replies_expected.size() == 0) begin
          report_mismatch("reply with no request pending", seen, 0);
        end else begin
          wanted = replies_expected.pop_front();
          if (seen.status != wanted.status)
            report_mismatch("status", seen.status, wanted.status);
          if (seen.granted != wanted.granted)
            report_mismatch("granted", seen.granted, wanted.granted);
          if (seen.new_slot != wanted.new_slot)
            report_mismatch("new_slot", seen.new_slot, wanted.new_slot);
        end
      end
      if (in_tvalid && in_tready) begin
        apply_bucket_op(in_tuser, in_tdata[mtb_pkg::IN_IDX_LSB +: mtb_pkg::INDEX_W],
                        in_tdata[mtb_pkg::IN_RATE_LSB +: mtb_pkg::AMOUNT_W],
                        in_tdata[mtb_pkg::IN_BURST_LSB +: mtb_pkg::AMOUNT_W],
                        in_tdata[mtb_pkg::IN_REQ_LSB +: mtb_pkg::AMOUNT_W], predicted);
        replies_expected.push_back(predicted);
      end
    end
    replies_due <= replies_expected.size();
  end

endmodule

// ----- bench/multi_token_bucket_table_test.sv -----
// ----------------------------------------------------------------------------
// multi_token_bucket_table_test: top of the token bucket table testbench
// Drives requests into the table, stalls the reply channel at random and
// gives the verdict; a separate scoreboard predicts and checks every reply.
// ----------------------------------------------------------------------------
module multi_token_bucket_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BUCKETS = mtb_pkg::NUM_BUCKETS_DEF;
  localparam int TOKEN_BITS  = mtb_pkg::TOKEN_BITS_DEF;

  // Opcodes the block does not define; it must answer them with a plain OK.
  localparam logic [mtb_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [mtb_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 1600;
  localparam int MAX_GAP      = 16;
  // The slowest correct transaction (a tick over a full table) plus the
  // longest gap on either side stays far below WATCHDOG_LIMIT, the number of
  // cycles the watchdog allows with nothing accepted.
  localparam int WATCHDOG_LIMIT = 1000;
  // Quiet spell after the last reply, long enough for any stray extra reply.
  localparam int TAIL_CYCLES = 40;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  // bucket_index[7:0], fill_rate[23:8], burst_limit[39:24], request_amount[55:40]
  logic [mtb_pkg::IN_DATA_W-1:0]  in_tdata;
  // opcode[2:0]
  logic [mtb_pkg::OP_W-1:0]       in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  // granted[15:0], new_slot[23:16]
  logic [mtb_pkg::OUT_DATA_W-1:0] out_tdata;
  // status[1:0]
  logic [mtb_pkg::STATUS_W-1:0]   out_tuser;

  int fail_count;
  int replies_due;

  // Each side switches now and then into a mode with no idling at all, so
  // that back-to-back transactions are covered as well as every kind of gap.
  bit send_flat_out;
  bit take_flat_out;

  always #6 clk = ~clk;

  multi_token_bucket_table #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .TOKEN_BITS (TOKEN_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  bucket_table_checker #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .TOKEN_BITS (TOKEN_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .replies_due(replies_due)
  );

  // Offers one request after a random gap and holds it until the block takes
  // it. Inputs only ever change on the falling edge, and the handshake is
  // looked at on the rising edge, so nothing hangs on event ordering.
  task automatic send_request(input logic [mtb_pkg::OP_W-1:0] op,
                              input logic [mtb_pkg::INDEX_W-1:0] idx,
                              input logic [mtb_pkg::AMOUNT_W-1:0] rate,
                              input logic [mtb_pkg::AMOUNT_W-1:0] burst,
                              input logic [mtb_pkg::AMOUNT_W-1:0] req);
    int unsigned gap;
    gap = send_flat_out ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {req, burst, rate, idx};
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  // Holds off new requests until every reply that is due has come back, so
  // that the block is also seen starting from a completely quiet state.
  task automatic drain_replies();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (replies_due != 0) @(negedge clk);
  endtask

  // Rate and burst come in several flavours: small values that make ticks
  // and fetches interact, the extremes, and the whole 16-bit range.
  function automatic logic [mtb_pkg::AMOUNT_W-1:0] draw_amount(input int unsigned small_max);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return mtb_pkg::AMOUNT_W'($urandom_range(0, small_max));
    if (pick == 5) return '0;
    if (pick == 6) return '1;
    return mtb_pkg::AMOUNT_W'($urandom());
  endfunction

  // Mostly well-formed requests on real slots, so that buckets actually fill,
  // saturate and drain; now and then an index beyond the table or an opcode
  // the block does not define.
  task automatic send_random_request();
    int unsigned                 pick;
    logic [mtb_pkg::OP_W-1:0]    op;
    logic [mtb_pkg::INDEX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    if (pick < 25)      op = mtb_pkg::OP_TICK;
    else if (pick < 45) op = mtb_pkg::OP_CREATE;
    else if (pick < 80) op = mtb_pkg::OP_FETCH;
    else if (pick < 92) op = mtb_pkg::OP_DESTROY;
    else if (pick < 95) op = mtb_pkg::OP_KILL_ALL;
    else                op = mtb_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    if ($urandom_range(0, 99) < 85) begin
      idx = mtb_pkg::INDEX_W'($urandom_range(0, NUM_BUCKETS - 1));
    end else begin
      idx = mtb_pkg::INDEX_W'($urandom_range(0, 255));
    end
    send_request(op, idx, draw_amount(60), draw_amount(400), draw_amount(150));
  endtask

  // Reply side: after every reply taken, ready drops for a random number of
  // cycles (possibly none) and then stays high until the next reply is taken.
  initial begin : reply_sink
    int unsigned stall;
    int          taken;
    taken         = 0;
    take_flat_out = 1'b0;
    out_tready    = 1'b0;
    @(posedge rst_n);
    forever begin
      if (taken % 64 == 0) take_flat_out = ($urandom_range(0, 3) == 0);
      stall = take_flat_out ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      taken++;
    end
  end

  // Ends the run if neither channel moves a transaction for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    send_flat_out = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = mtb_pkg::OP_TICK;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. First the error paths on an empty table: a fetch and a
    // destroy on a free slot, both with the index at its lowest, then the
    // same with indices past the end of the table, and a tick with nothing
    // live.
    send_request(mtb_pkg::OP_FETCH, '0, '1, '1, '1);
    send_request(mtb_pkg::OP_DESTROY, '0, '0, '0, '0);
    send_request(mtb_pkg::OP_FETCH, '1, '0, '0, '1);
    send_request(mtb_pkg::OP_DESTROY, mtb_pkg::INDEX_W'(NUM_BUCKETS), '1, '1, '0);
    send_request(mtb_pkg::OP_TICK, '1, '1, '1, '1);

    // Fill every slot. The first bucket has the largest rate and burst so a
    // tick has to saturate at the top of the count range, the second has
    // both at zero, and the third gets a burst that is not a multiple of its
    // rate so the clipping shows.
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      if (i == 0) begin
        send_request(mtb_pkg::OP_CREATE, '1, '1, '1, '0);
      end else if (i == 1) begin
        send_request(mtb_pkg::OP_CREATE, '0, '0, '0, '1);
      end else if (i == 2) begin
        send_request(mtb_pkg::OP_CREATE, '0, 16'd100, 16'd250, '0);
      end else begin
        send_request(mtb_pkg::OP_CREATE, '0, draw_amount(60), draw_amount(400), '0);
      end
    end
    // The table is full now, so this create must be refused.
    send_request(mtb_pkg::OP_CREATE, '0, 16'd5, 16'd5, '0);
    send_request(mtb_pkg::OP_TICK, '0, '0, '0, '0);
    send_request(mtb_pkg::OP_TICK, '0, '0, '0, '0);
    send_request(mtb_pkg::OP_TICK, '0, '0, '0, '0);

    // Largest request against a saturated bucket, a zero request, a request
    // against an empty bucket, and one larger than the tokens held.
    send_request(mtb_pkg::OP_FETCH, 8'd0, '0, '0, '1);
    send_request(mtb_pkg::OP_FETCH, 8'd2, '0, '0, '0);
    send_request(mtb_pkg::OP_FETCH, 8'd1, '0, '0, 16'd5);
    send_request(mtb_pkg::OP_FETCH, 8'd2, '0, '0, 16'd1000);

    // Free a slot in the middle and check that a create takes it again.
    send_request(mtb_pkg::OP_DESTROY, 8'd3, '0, '0, '0);
    send_request(mtb_pkg::OP_CREATE, '0, 16'd7, 16'd20, '0);

    // Undefined opcodes with every data bit set.
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) begin
      send_request(mtb_pkg::OP_W'(op), '1, '1, '1, '1);
    end
    send_request(mtb_pkg::OP_KILL_ALL, '0, '0, '0, '0);
    send_request(mtb_pkg::OP_FETCH, 8'd0, '0, '0, 16'd1);

    drain_replies();

    // Random part, with one more full drain half way through.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) send_flat_out = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) drain_replies();
      send_random_request();
    end

    // Wait for the last replies, then a short quiet spell in which any
    // extra reply would still be caught by the scoreboard.
    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
